>>> rtl/spsi_pkg.sv
// ----------------------------------------------------------------------------
// spsi_pkg: shared widths, constants and control types
// widths of the swept point / segment impact datapath, derived from the
// coordinate and ratio formats
// ----------------------------------------------------------------------------
package spsi_pkg;

	localparam int COORD_BITS      = 24;
	localparam int RATIO_FRAC_BITS = 16;

	// coordinate difference, cross product, ratio and quotient widths
	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int XW      = 2 * COORD_BITS + 2;
	localparam int RATIO_W = RATIO_FRAC_BITS + 3;
	localparam int QUOT_W  = RATIO_FRAC_BITS + 1;

	// tolerance register, fixed 17 bit field, reset 1/4096 of Q.16
	localparam int TOL_W = 17;
	localparam logic [TOL_W-1:0] TOL_RESET = 17'd16;
	localparam int CMP_W = (QUOT_W > TOL_W) ? QUOT_W : TOL_W;

	// serial step counts
	localparam int MUL_STEPS = DIFF_W;
	localparam int DIV_STEPS = QUOT_W;
	localparam int CNT_W = $clog2((MUL_STEPS > DIV_STEPS) ? MUL_STEPS : DIV_STEPS);

	// stream widths, whole bytes
	localparam int IN_DATA_W  = ((8 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((2 * RATIO_W + 7) / 8) * 8;

	// ratio codes
	localparam logic signed [RATIO_W-1:0] NO_BLOCK  = RATIO_W'(64'sd2 << RATIO_FRAC_BITS);
	localparam logic signed [RATIO_W-1:0] ONE_RATIO = RATIO_W'(64'sd1 << RATIO_FRAC_BITS);

	typedef struct packed {
		logic step;
		logic first;
	} mac_ctl_t;

	typedef struct packed {
		logic load;
		logic step;
		logic first;
	} div_ctl_t;

endpackage

>>> rtl/swept_point_segment_impact_core.sv
// ----------------------------------------------------------------------------
// swept_point_segment_impact_core: swept point against wall segment
// finds the move fraction t at which a point meets a segment, with a
// running minimum over a run of requests
// ----------------------------------------------------------------------------
//
// channel   direction  handshake          payload
// s_*       in         tvalid / tready    8 coordinates, facing flag, last pair
// m_*       out        tvalid / tready    pair ratio, run minimum, blocks, done
// cfg_*     in         valid / ready      tolerance, 17 bits
//
// a request runs the bit-serial cross products, takes their magnitudes and
// signs, then applies the exact cross product tests; a request that these
// tests reject skips the radix-2 division, any other runs it before the
// result is written to the output register
// one request is in work at a time; the next is taken once the result sits in
// the output register, even while that result is stalled
// a stalled output holds the last step until the register frees
// reset clears control state, the running minimum and the tolerance (16)
//
module swept_point_segment_impact_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// seg_start_x, seg_start_y, seg_end_x, seg_end_y,
	// point_x, point_y, move_x, move_y, lowest first
	input  logic [spsi_pkg::IN_DATA_W-1:0]        s_tdata,
	input  logic                                  s_tuser,   // facing_check
	input  logic                                  s_tlast,   // last_pair
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// pair_ratio, run_minimum, lowest first
	output logic [spsi_pkg::OUT_DATA_W-1:0]       m_tdata,
	output logic                                  m_tuser,   // pair_blocks
	output logic                                  m_tlast,   // run_done
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	input  logic [spsi_pkg::TOL_W-1:0]            cfg_data,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready
);

	localparam int CW = spsi_pkg::COORD_BITS;
	localparam int DW = spsi_pkg::DIFF_W;
	localparam int XW = spsi_pkg::XW;
	localparam int RW = spsi_pkg::RATIO_W;
	localparam int QW = spsi_pkg::QUOT_W;
	localparam int NW = spsi_pkg::CNT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ABS,
		ST_CMP,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;
	logic [NW-1:0] cnt_q;
	logic [spsi_pkg::TOL_W-1:0] tol_q;
	logic signed [RW-1:0] run_min_q;
	logic m_tvalid_q;
	logic m_tuser_q;
	logic m_tlast_q;
	logic [spsi_pkg::OUT_DATA_W-1:0] m_tdata_q;

	// unpacked request fields
	logic signed [CW-1:0] in_sx, in_sy, in_ex, in_ey, in_px, in_py, in_mx, in_my;
	assign in_sx = s_tdata[0*CW +: CW];
	assign in_sy = s_tdata[1*CW +: CW];
	assign in_ex = s_tdata[2*CW +: CW];
	assign in_ey = s_tdata[3*CW +: CW];
	assign in_px = s_tdata[4*CW +: CW];
	assign in_py = s_tdata[5*CW +: CW];
	assign in_mx = s_tdata[6*CW +: CW];
	assign in_my = s_tdata[7*CW +: CW];

	logic s_acc;
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// segment direction g = e - s, point offset d = p - s
	logic signed [DW-1:0] gx_q, gy_q, dx_q, dy_q;
	// multiplier bit shift registers, msb first
	logic [DW-1:0] mx_sh_q, my_sh_q, dx_sh_q, dy_sh_q;
	logic facing_q;
	logic last_q;

	// serial cross products
	spsi_pkg::mac_ctl_t mac_ctl;
	logic signed [XW-1:0] den_x, un_x, tn_x;

	assign mac_ctl.step  = (state_q == ST_MUL);
	assign mac_ctl.first = (cnt_q == '0);

	// den = g x m
	spsi_cross_mac u_mac_den (
		.clk   (clk),
		.ctl   (mac_ctl),
		.bit_a (my_sh_q[DW-1]),
		.bit_b (mx_sh_q[DW-1]),
		.op_a  (gx_q),
		.op_b  (gy_q),
		.acc   (den_x)
	);

	// u numerator = m x (-d)
	spsi_cross_mac u_mac_un (
		.clk   (clk),
		.ctl   (mac_ctl),
		.bit_a (my_sh_q[DW-1]),
		.bit_b (mx_sh_q[DW-1]),
		.op_a  (dx_q),
		.op_b  (dy_q),
		.acc   (un_x)
	);

	// t numerator = g x d
	spsi_cross_mac u_mac_tn (
		.clk   (clk),
		.ctl   (mac_ctl),
		.bit_a (dy_sh_q[DW-1]),
		.bit_b (dx_sh_q[DW-1]),
		.op_a  (gx_q),
		.op_b  (gy_q),
		.acc   (tn_x)
	);

	// magnitudes and sign flags
	logic [XW-1:0] ad_q, au_q, at_q;
	logic den_neg_q, den_zero_q, un_neg_q, un_zero_q, tn_neg_q, tn_zero_q;
	logic nb_q;
	logic tneg_q;
	logic reject;

	assign reject = den_zero_q
		|| (facing_q && den_neg_q)
		|| (!un_zero_q && (un_neg_q != den_neg_q))
		|| (ad_q < au_q)
		|| (ad_q < at_q);

	// divider for |t|
	spsi_pkg::div_ctl_t div_ctl;
	logic [QW-1:0] quot;
	logic quot_exact;

	assign div_ctl.load  = (state_q == ST_CMP);
	assign div_ctl.step  = (state_q == ST_DIV);
	assign div_ctl.first = (cnt_q == '0);

	spsi_serial_div u_div (
		.clk   (clk),
		.ctl   (div_ctl),
		.num   (at_q),
		.den   (ad_q),
		.quot  (quot),
		.exact (quot_exact)
	);

	// final ratio
	logic [spsi_pkg::CMP_W-1:0] q_ext, tol_ext;
	logic signed [RW-1:0] ratio;
	logic signed [RW-1:0] new_min;

	assign q_ext   = spsi_pkg::CMP_W'(quot);
	assign tol_ext = spsi_pkg::CMP_W'(tol_q);

	always_comb begin
		priority if (nb_q) begin
			ratio = spsi_pkg::NO_BLOCK;
		end else if (!tneg_q) begin
			ratio = $signed(RW'(quot));
		end else if (!facing_q) begin
			ratio = spsi_pkg::NO_BLOCK;
		end else if ((q_ext < tol_ext) || ((q_ext == tol_ext) && quot_exact)) begin
			// small accepted negative t, sign applied after truncation
			ratio = -$signed(RW'(quot));
		end else begin
			ratio = spsi_pkg::NO_BLOCK;
		end
	end

	assign new_min = (ratio < run_min_q) ? ratio : run_min_q;

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (s_acc) begin
			gx_q    <= DW'(in_ex) - DW'(in_sx);
			gy_q    <= DW'(in_ey) - DW'(in_sy);
			dx_q    <= DW'(in_px) - DW'(in_sx);
			dy_q    <= DW'(in_py) - DW'(in_sy);
			dx_sh_q <= DW'(in_px) - DW'(in_sx);
			dy_sh_q <= DW'(in_py) - DW'(in_sy);
			mx_sh_q <= DW'(in_mx);
			my_sh_q <= DW'(in_my);
			facing_q <= s_tuser;
			last_q   <= s_tlast;
		end else if (state_q == ST_MUL) begin
			mx_sh_q <= {mx_sh_q[DW-2:0], 1'b0};
			my_sh_q <= {my_sh_q[DW-2:0], 1'b0};
			dx_sh_q <= {dx_sh_q[DW-2:0], 1'b0};
			dy_sh_q <= {dy_sh_q[DW-2:0], 1'b0};
		end
		if (state_q == ST_ABS) begin
			ad_q       <= den_x[XW-1] ? XW'(-den_x) : XW'(den_x);
			au_q       <= un_x[XW-1] ? XW'(-un_x) : XW'(un_x);
			at_q       <= tn_x[XW-1] ? XW'(-tn_x) : XW'(tn_x);
			den_neg_q  <= den_x[XW-1];
			un_neg_q   <= un_x[XW-1];
			tn_neg_q   <= tn_x[XW-1];
			den_zero_q <= (den_x == '0);
			un_zero_q  <= (un_x == '0);
			tn_zero_q  <= (tn_x == '0);
		end
		if (state_q == ST_CMP) begin
			nb_q   <= reject;
			// t below zero when its numerator shares the sign of den
			tneg_q <= !tn_zero_q && (tn_neg_q == den_neg_q);
		end
	end

	// control, running minimum, tolerance and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			tol_q      <= spsi_pkg::TOL_RESET;
			run_min_q  <= spsi_pkg::NO_BLOCK;
			m_tvalid_q <= 1'b0;
			m_tuser_q  <= 1'b0;
			m_tlast_q  <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tol_q <= cfg_data;
			end
			// the final step reloads the register itself when it frees
			if (m_tvalid_q && m_tready && (state_q != ST_FIN)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (s_acc) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (cnt_q == NW'(spsi_pkg::MUL_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_ABS;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ABS: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					cnt_q   <= '0;
					// exact rejects skip the division
					state_q <= reject ? ST_FIN : ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == NW'(spsi_pkg::DIV_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FIN: begin
					// wait for a free output register
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= spsi_pkg::OUT_DATA_W'({new_min, ratio});
						m_tuser_q  <= (ratio <= spsi_pkg::ONE_RATIO);
						m_tlast_q  <= last_q;
						run_min_q  <= last_q ? spsi_pkg::NO_BLOCK : new_min;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

>>> rtl/spsi_cross_mac.sv
// ----------------------------------------------------------------------------
// spsi_cross_mac: bit-serial cross product accumulator
// forms a*y - b*x one multiplier bit pair per cycle, msb first
// ----------------------------------------------------------------------------
module spsi_cross_mac (
	input  logic                                   clk,
	input  spsi_pkg::mac_ctl_t                     ctl,
	input  logic                                   bit_a,
	input  logic                                   bit_b,
	input  logic signed [spsi_pkg::DIFF_W-1:0]     op_a,
	input  logic signed [spsi_pkg::DIFF_W-1:0]     op_b,
	output logic signed [spsi_pkg::XW-1:0]         acc
);

	logic signed [spsi_pkg::XW-1:0] sel_a;
	logic signed [spsi_pkg::XW-1:0] sel_b;
	logic signed [spsi_pkg::XW-1:0] term;
	logic signed [spsi_pkg::XW-1:0] acc_q;

	assign sel_a = bit_a ? spsi_pkg::XW'(op_a) : '0;
	assign sel_b = bit_b ? spsi_pkg::XW'(op_b) : '0;
	assign term  = sel_a - sel_b;

	// sign bit of the multiplier carries negative weight
	always_ff @(posedge clk) begin
		if (ctl.step) begin
			acc_q <= ctl.first ? -term : (acc_q <<< 1) + term;
		end
	end

	assign acc = acc_q;

endmodule

>>> rtl/spsi_serial_div.sv
// ----------------------------------------------------------------------------
// spsi_serial_div: radix-2 restoring divider
// floor(num * 2^f / den) for num <= den, one quotient bit per cycle
// ----------------------------------------------------------------------------
module spsi_serial_div (
	input  logic                               clk,
	input  spsi_pkg::div_ctl_t                 ctl,
	input  logic [spsi_pkg::XW-1:0]            num,
	input  logic [spsi_pkg::XW-1:0]            den,
	output logic [spsi_pkg::QUOT_W-1:0]        quot,
	output logic                               exact
);

	logic [spsi_pkg::XW-1:0]     rem_q;
	logic [spsi_pkg::XW-1:0]     den_q;
	logic [spsi_pkg::QUOT_W-1:0] quot_q;
	logic [spsi_pkg::XW:0]       trial;
	logic [spsi_pkg::XW:0]       diff;
	logic                        ge;

	// integer bit first, then one shift per fraction bit
	assign trial = ctl.first ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (ctl.step) begin
			rem_q  <= ge ? diff[spsi_pkg::XW-1:0] : trial[spsi_pkg::XW-1:0];
			quot_q <= {quot_q[spsi_pkg::QUOT_W-2:0], ge};
		end
	end

	assign quot  = quot_q;
	assign exact = (rem_q == '0);

endmodule

>>> rtl/spsi_checker.sv
// ----------------------------------------------------------------------------
// spsi_checker: port-level checks for the impact core
// watches the stream ports over time, bound to the top level
// ----------------------------------------------------------------------------
module spsi_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	input  logic                                  s_tready,
	input  logic [spsi_pkg::OUT_DATA_W-1:0]       m_tdata,
	input  logic                                  m_tuser,
	input  logic                                  m_tvalid,
	input  logic                                  m_tready
);

	localparam int RW = spsi_pkg::RATIO_W;

	logic signed [RW-1:0] ratio;
	logic signed [RW-1:0] run_min;

	assign ratio   = m_tdata[RW-1:0];
	assign run_min = m_tdata[2*RW-1:RW];

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// blocks flag agrees with ratio
	a_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == (ratio <= spsi_pkg::ONE_RATIO)))
		else $error("pair_blocks disagrees with pair_ratio");

	// running minimum never above this pair
	a_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (run_min <= ratio))
		else $error("run_minimum above pair_ratio");

	// ratio is no block or within minus one to one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((ratio == spsi_pkg::NO_BLOCK)
			|| ((ratio <= spsi_pkg::ONE_RATIO) && (ratio >= -spsi_pkg::ONE_RATIO))))
		else $error("pair_ratio out of range");

	// one request in work at a time
	a_serial: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

endmodule

bind swept_point_segment_impact_core spsi_checker u_spsi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

>>> tb/sv/swept_point_segment_impact_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swept_point_segment_impact_core_test: self-checking bench for the impact core
// streams segment / point / move requests through the core and compares every
// result against a cycle-free impact ratio and run minimum computation, across
// several tolerance settings and with random gaps on both stream sides
// ----------------------------------------------------------------------------
module swept_point_segment_impact_core_test;

	localparam int unsigned SETTLE_CYCLES = 64;       // longer than a request through the division path
	localparam int unsigned CYCLE_LIMIT   = 400_000;  // upper bound on the whole run
	localparam int unsigned RANDOM_PER_PHASE = 100;

	// eight coordinates, seg_start_x in the lowest bits as on s_tdata
	typedef struct packed {
		logic signed [spsi_pkg::COORD_BITS-1:0] move_y;
		logic signed [spsi_pkg::COORD_BITS-1:0] move_x;
		logic signed [spsi_pkg::COORD_BITS-1:0] point_y;
		logic signed [spsi_pkg::COORD_BITS-1:0] point_x;
		logic signed [spsi_pkg::COORD_BITS-1:0] seg_end_y;
		logic signed [spsi_pkg::COORD_BITS-1:0] seg_end_x;
		logic signed [spsi_pkg::COORD_BITS-1:0] seg_start_y;
		logic signed [spsi_pkg::COORD_BITS-1:0] seg_start_x;
	} coord_set_t;

	typedef struct {
		coord_set_t c;
		logic       facing;
		logic       last;
	} impact_req_t;

	typedef struct {
		logic signed [spsi_pkg::RATIO_W-1:0] ratio;
		logic signed [spsi_pkg::RATIO_W-1:0] run_min;
		logic                                blocks;
		logic                                done;
	} impact_result_t;

	// expected impact results, one per accepted request, oldest first
	class impact_scoreboard;
		logic [spsi_pkg::TOL_W-1:0]          tolerance;
		logic signed [spsi_pkg::RATIO_W-1:0] run_min;
		impact_result_t                      expected_q[$];
		int unsigned                         mismatches;
		int unsigned                         results_checked;
		int unsigned                         blocking_results;
		int unsigned                         negative_ratios;
		int unsigned                         runs_closed;

		function new();
			tolerance = spsi_pkg::TOL_RESET;
			run_min   = spsi_pkg::NO_BLOCK;
		endfunction

		function longint mag(longint v);
			return (v < 0) ? -v : v;
		endfunction

		// exact cross product tests, then truncated |t| in Q.16
		function logic signed [spsi_pkg::RATIO_W-1:0] impact_ratio(impact_req_t r);
			longint sx, sy, gx, gy, dx, dy, mx, my;
			longint den, un, tn, td, at, ad, rem, q;
			bit     tneg;
			sx = r.c.seg_start_x;
			sy = r.c.seg_start_y;
			gx = longint'(r.c.seg_end_x) - sx;
			gy = longint'(r.c.seg_end_y) - sy;
			dx = longint'(r.c.point_x) - sx;
			dy = longint'(r.c.point_y) - sy;
			mx = r.c.move_x;
			my = r.c.move_y;
			den = gx * my - gy * mx;
			if (den == 0)
				return spsi_pkg::NO_BLOCK;
			if (r.facing && den < 0)
				return spsi_pkg::NO_BLOCK;
			un = mx * (-dy) - my * (-dx);
			if (un != 0 && ((un < 0) != (den < 0)))
				return spsi_pkg::NO_BLOCK;
			if (mag(den) < mag(un))
				return spsi_pkg::NO_BLOCK;
			tn = gx * dy - gy * dx;
			td = -den;
			at = mag(tn);
			ad = mag(td);
			if (ad < at)
				return spsi_pkg::NO_BLOCK;
			// restoring division, remainder stays below ad
			rem = at;
			q = 0;
			if (rem >= ad) begin
				rem = rem - ad;
				q = 1;
			end
			for (int i = 0; i < spsi_pkg::RATIO_FRAC_BITS; i++) begin
				rem = rem << 1;
				q = q << 1;
				if (rem >= ad) begin
					rem = rem - ad;
					q = q | 1;
				end
			end
			tneg = (tn != 0) && ((tn < 0) != (td < 0));
			if (!tneg)
				return spsi_pkg::RATIO_W'(q);
			if (!r.facing)
				return spsi_pkg::NO_BLOCK;
			if (q < tolerance || (q == tolerance && rem == 0))
				return spsi_pkg::RATIO_W'(-q);
			return spsi_pkg::NO_BLOCK;
		endfunction

		function void note_request(impact_req_t r);
			impact_result_t e;
			e.ratio   = impact_ratio(r);
			e.blocks  = (e.ratio <= spsi_pkg::ONE_RATIO);
			e.run_min = (e.ratio < run_min) ? e.ratio : run_min;
			e.done    = r.last;
			run_min   = r.last ? spsi_pkg::NO_BLOCK : e.run_min;
			expected_q.insert(expected_q.size(), e);
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void compare_field(string name, longint exp_v, longint act_v);
			if (exp_v != act_v) begin
				mismatches++;
				$display("%0t ns: %s mismatch, expected %0d, actual %0d",
					$time, name, exp_v, act_v);
			end
		endfunction

		function void check_result(logic [spsi_pkg::OUT_DATA_W-1:0] data, logic blocks,
				logic done);
			impact_result_t e;
			logic signed [spsi_pkg::RATIO_W-1:0] ratio, rmin;
			ratio = data[spsi_pkg::RATIO_W-1:0];
			rmin  = data[2*spsi_pkg::RATIO_W-1:spsi_pkg::RATIO_W];
			if (expected_q.size() == 0) begin
				mismatches++;
				$display("%0t ns: unexpected result, actual ratio %0d run_min %0d",
					$time, ratio, rmin);
				return;
			end
			e = expected_q.pop_front();
			compare_field("pair_ratio", e.ratio, ratio);
			compare_field("pair_blocks", e.blocks, blocks);
			compare_field("run_minimum", e.run_min, rmin);
			compare_field("run_done", e.done, done);
			results_checked++;
			if (e.blocks)
				blocking_results++;
			if (e.ratio < 0)
				negative_ratios++;
			if (e.done)
				runs_closed++;
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic [spsi_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic                            s_tuser = 1'b0;
	logic                            s_tlast = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [spsi_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            m_tuser;
	logic                            m_tlast;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [spsi_pkg::TOL_W-1:0]      cfg_data = '0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;

	impact_scoreboard sb;
	int unsigned      idle_pct = 0;
	int unsigned      stall_pct = 0;
	int unsigned      cycle_count = 0;
	int unsigned      tolerance_writes = 0;

	swept_point_segment_impact_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_data  (cfg_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result side: check on handshake, then pick next cycle's ready
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser, m_tlast);
		m_tready <= ($urandom_range(99, 0) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t ns: timeout, %0d results still expected", $time, sb.pending());
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic impact_req_t make_req(longint sx, longint sy, longint ex, longint ey,
			longint px, longint py, longint mx, longint my, logic facing, logic last);
		impact_req_t r;
		r.c.seg_start_x = spsi_pkg::COORD_BITS'(sx);
		r.c.seg_start_y = spsi_pkg::COORD_BITS'(sy);
		r.c.seg_end_x   = spsi_pkg::COORD_BITS'(ex);
		r.c.seg_end_y   = spsi_pkg::COORD_BITS'(ey);
		r.c.point_x     = spsi_pkg::COORD_BITS'(px);
		r.c.point_y     = spsi_pkg::COORD_BITS'(py);
		r.c.move_x      = spsi_pkg::COORD_BITS'(mx);
		r.c.move_y      = spsi_pkg::COORD_BITS'(my);
		r.facing        = facing;
		r.last          = last;
		return r;
	endfunction

	// signed value in [-2^sh, 2^sh - 1]
	function automatic longint spread(int sh);
		return longint'($urandom_range((1 << (sh + 1)) - 1, 0)) - (longint'(1) << sh);
	endfunction

	// point placed so that its path meets the segment near a chosen u and t
	function automatic impact_req_t aimed_request(logic facing);
		int     sh;
		longint sx, sy, ex, ey, mx, my, ix, iy, k, j;
		sh = $urandom_range(21, 2);
		sx = spread(sh);
		sy = spread(sh);
		ex = spread(sh);
		ey = spread(sh);
		mx = spread(sh);
		my = spread(sh);
		k  = longint'($urandom_range(264, 0)) - 4;
		ix = sx + (((ex - sx) * k) >>> 8);
		iy = sy + (((ey - sy) * k) >>> 8);
		// t in 1/65536 steps: mostly the whole range, often near zero
		if ($urandom_range(3, 0) == 0)
			j = longint'($urandom_range(600, 0)) - 300;
		else
			j = longint'($urandom_range(66536, 0)) - 500;
		return make_req(sx, sy, ex, ey, ix - ((mx * j) >>> 16), iy - ((my * j) >>> 16),
			mx, my, facing, 1'b0);
	endfunction

	// parallel move, zero move or zero-length segment
	function automatic impact_req_t degenerate_request(logic facing);
		impact_req_t r;
		r = aimed_request(facing);
		case ($urandom_range(2, 0))
			0: begin
				r.c.move_x = r.c.seg_start_x - r.c.seg_end_x;
				r.c.move_y = r.c.seg_start_y - r.c.seg_end_y;
			end
			1: begin
				r.c.move_x = '0;
				r.c.move_y = '0;
			end
			default: begin
				r.c.seg_end_x = r.c.seg_start_x;
				r.c.seg_end_y = r.c.seg_start_y;
			end
		endcase
		return r;
	endfunction

	function automatic impact_req_t noise_request();
		return make_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom_range(1, 0), 1'b0);
	endfunction

	task automatic send_request(impact_req_t r);
		while ($urandom_range(99, 0) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata  <= r.c;
		s_tuser  <= r.facing;
		s_tlast  <= r.last;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_request(r);
	endtask

	// hold the sender until every expected result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_tolerance(logic [spsi_pkg::TOL_W-1:0] value);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.tolerance = value;
		tolerance_writes++;
	endtask

	// vertical wall at x = 0, move of -1.0 in x: t equals px / 65536
	task automatic tolerance_probe();
		longint tol;
		tol = sb.tolerance;
		send_request(make_req(0, -256, 0, 256, -tol, 0, -65536, 0, 1'b1, 1'b0));
		send_request(make_req(0, -256, 0, 256, -tol - 1, 0, -65536, 0, 1'b1, 1'b0));
		send_request(make_req(0, -256, 0, 256, (tol > 0) ? 1 - tol : 1, 0, -65536, 0,
			1'b1, 1'b1));
	endtask

	task automatic random_requests(int unsigned count);
		impact_req_t r;
		int unsigned pick;
		logic        facing;
		for (int unsigned n = 0; n < count; n++) begin
			pick   = $urandom_range(99, 0);
			facing = $urandom_range(1, 0);
			if (pick < 65)
				r = aimed_request(facing);
			else if (pick < 80)
				r = noise_request();
			else
				r = degenerate_request(facing);
			r.last = ($urandom_range(4, 0) == 0);
			if ($urandom_range(79, 0) == 0)
				drain_results();
			send_request(r);
		end
	endtask

	// wall from (0,-1) to (0,1), move of -1.0 in x unless stated
	task automatic directed_requests();
		send_request(make_req(0, -256, 0, 256, 128, 0, -256, 0, 1'b0, 1'b0));
		send_request(make_req(0, -256, 0, 256, 256, 0, -256, 0, 1'b0, 1'b0));
		send_request(make_req(0, -256, 0, 256, 257, 0, -256, 0, 1'b0, 1'b0));
		send_request(make_req(0, -256, 0, 256, 0, 0, -256, 0, 1'b1, 1'b0));
		// negative t without facing check, then beyond default slack
		send_request(make_req(0, -256, 0, 256, -1, 0, -256, 0, 1'b0, 1'b0));
		send_request(make_req(0, -256, 0, 256, -1, 0, -256, 0, 1'b1, 1'b0));
		// parallel move, zero move, zero-length segment
		send_request(make_req(0, -256, 0, 256, 128, 0, 0, 256, 1'b0, 1'b0));
		send_request(make_req(0, -256, 0, 256, 128, 0, 0, 0, 1'b0, 1'b0));
		send_request(make_req(0, 0, 0, 0, 128, 0, -256, 0, 1'b0, 1'b0));
		// segment facing away from the move, with and without facing check
		send_request(make_req(0, -256, 0, 256, -128, 0, 256, 0, 1'b1, 1'b0));
		send_request(make_req(0, -256, 0, 256, -128, 0, 256, 0, 1'b0, 1'b1));
		// segment parameter at and just past both ends
		send_request(make_req(0, -256, 0, 256, 128, 256, -256, 0, 1'b0, 1'b0));
		send_request(make_req(0, -256, 0, 256, 128, -256, -256, 0, 1'b0, 1'b0));
		send_request(make_req(0, -256, 0, 256, 128, 257, -256, 0, 1'b0, 1'b0));
		send_request(make_req(0, -256, 0, 256, 128, -257, -256, 0, 1'b0, 1'b0));
		// slack boundary at the reset tolerance, exact quotients
		send_request(make_req(0, -256, 0, 256, -16, 0, -65536, 0, 1'b1, 1'b0));
		send_request(make_req(0, -256, 0, 256, -17, 0, -65536, 0, 1'b1, 1'b0));
		send_request(make_req(0, -256, 0, 256, -15, 0, -65536, 0, 1'b1, 1'b0));
		// move of -3.0: equal truncated quotient with and without remainder
		send_request(make_req(0, -256, 0, 256, -48, 0, -196608, 0, 1'b1, 1'b0));
		send_request(make_req(0, -256, 0, 256, -49, 0, -196608, 0, 1'b1, 1'b0));
		// tiny accepted negative t truncates to zero
		send_request(make_req(0, -256, 0, 256, -1, 0, -196608, 0, 1'b1, 1'b1));
		// coordinate extremes
		send_request(make_req(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
			-8388608, -8388608, 1'b1, 1'b0));
		send_request(make_req(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
			8388607, 8388607, 1'b0, 1'b0));
		send_request(make_req(-8388608, -8388608, 8388607, 8388607, 8388607, -8388608,
			-8388608, 8388607, 1'b0, 1'b1));
	endtask

	task automatic run_phase(logic [spsi_pkg::TOL_W-1:0] tol, int unsigned idle,
			int unsigned stall);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_tolerance(tol);
		idle_pct  = idle;
		stall_pct = stall;
		tolerance_probe();
		random_requests(RANDOM_PER_PHASE);
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset tolerance, no gaps on either side
		directed_requests();
		random_requests(RANDOM_PER_PHASE);

		run_phase(17'd0, 54, 0);
		run_phase(17'd65536, 0, 54);
		run_phase(17'd256, 36, 36);
		run_phase(17'd1, 0, 0);
		run_phase(spsi_pkg::TOL_W'($urandom_range(1024, 0)), 54, 54);
		run_phase(17'd16, 36, 36);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("checked %0d results: %0d blocking, %0d negative ratios, %0d runs closed",
			sb.results_checked, sb.blocking_results, sb.negative_ratios, sb.runs_closed);
		$display("over %0d tolerance writes with sender gaps and receiver stalls",
			tolerance_writes);
		if (sb.pending() != 0)
			$display("%0t ns: %0d expected results never arrived", $time, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
